### sv/urde_pkg.sv
// Package for the UART register datagram encoder.
// Holds the beat types, frame constants and the CRC-8 byte update.
// No dependencies.
package urde_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h05;
   localparam logic [7:0] WRITE_FLAG = 8'h80;
   localparam logic [7:0] CRC_POLY   = 8'h07;
   localparam logic [7:0] CRC_INIT   = 8'h00;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   localparam int FRAME_BYTES = 8;
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   localparam logic [IDX_W-1:0] LAST_WRITE = IDX_W'(7);
   localparam logic [IDX_W-1:0] LAST_READ  = IDX_W'(3);

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        mode;
      logic [7:0]  node_addr;
      logic [6:0]  reg_addr;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   // One datagram ready for transmission: the header and data bytes in
   // transmit order and the position of the CRC byte.
   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] frame;
      logic [IDX_W-1:0]            last_idx;
   } desc_type;

   // Feeds one byte into the CRC, least significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc;
      for (int b = 0; b < 8; b++) begin
         if (acc[7] ^ data[b]) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

### sv/urde_front.sv
// Front end of the datagram encoder: accepts requests, builds the frame
// bytes and holds them in a two-entry queue for the back end.
// Depends on urde_pkg.
module urde_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  urde_pkg::req_type  req,
   output logic               desc_valid,
   input  logic               desc_ready,
   output urde_pkg::desc_type desc
);

   urde_pkg::desc_type slot_ff [urde_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   urde_pkg::desc_type built;

   always_comb begin
      built.frame    = '0;
      built.frame[0] = urde_pkg::SYNC_BYTE;
      built.frame[1] = req.node_addr;
      case (req.mode)
         urde_pkg::MODE_WRITE: begin
            built.frame[2] = urde_pkg::WRITE_FLAG | {1'b0, req.reg_addr};
            built.frame[3] = req.write_data[31:24];
            built.frame[4] = req.write_data[23:16];
            built.frame[5] = req.write_data[15:8];
            built.frame[6] = req.write_data[7:0];
            built.last_idx = urde_pkg::LAST_WRITE;
         end
         default: begin
            built.frame[2] = {1'b0, req.reg_addr};
            built.last_idx = urde_pkg::LAST_READ;
         end
      endcase
   end

   assign req_ready  = (count_ff != 2'(urde_pkg::QUEUE_DEPTH));
   assign desc_valid = (count_ff != 2'd0);
   assign desc       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = desc_valid && desc_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= built;
      end
   end

endmodule

### sv/urde_back.sv
// Back end of the datagram encoder: walks one queued frame a byte per
// cycle while the result beat is free to advance, runs the CRC-8 and drives the registered result beat.
// Depends on urde_pkg.
module urde_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_valid,
   output logic               desc_ready,
   input  urde_pkg::desc_type desc,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output urde_pkg::rsp_type  rsp
);

   logic                       cur_valid_ff, cur_valid_in;
   urde_pkg::desc_type         cur_ff;
   logic [urde_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]                 crc_ff, crc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   urde_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       out_free;
   logic                       advance;
   logic                       is_last;
   logic                       load;
   logic [7:0]                 cur_byte;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = cur_valid_ff && out_free;
   assign is_last    = (idx_ff == cur_ff.last_idx);
   assign load       = !cur_valid_ff || (advance && is_last);
   assign desc_ready = load;
   assign cur_byte   = is_last ? crc_ff : cur_ff.frame[idx_ff];

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      if (load) begin
         cur_valid_in = desc_valid;
         idx_in       = '0;
         crc_in       = urde_pkg::CRC_INIT;
      end else if (advance) begin
         idx_in = idx_ff + {{(urde_pkg::IDX_W-1){1'b0}}, 1'b1};
         crc_in = urde_pkg::crc8_byte(crc_ff, cur_byte);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in   = cur_valid_ff;
         rsp_in.tx_byte = cur_byte;
         rsp_in.last    = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         crc_ff       <= urde_pkg::CRC_INIT;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (load) begin
         cur_ff <= desc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### sv/uart_register_datagram_encoder_unit.sv
// Top level of the UART register datagram encoder.
// Depends on urde_pkg, urde_front and urde_back.
//
// Each request beat becomes one datagram on the rsp channel, one byte per
// beat in transmit order, with last set on the closing CRC-8 byte: eight
// beats for a write request, four for a read request. The back end emits at
// most one byte per cycle, and holds while rsp is stalled; frames follow each
// other with no gap when the next request is already queued. A
// two-entry queue between the request side and the byte serializer lets
// up to two further requests be taken while a datagram is still being sent.
module uart_register_datagram_encoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  urde_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output urde_pkg::rsp_type rsp
);

   logic               desc_valid;
   logic               desc_ready;
   urde_pkg::desc_type desc;

   urde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .desc       (desc)
   );

   urde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .desc       (desc),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

### sv/urde_checker.sv
// Port-level checks for the UART register datagram encoder, with the bind
// that attaches them to the top level.
// Depends on urde_pkg and uart_register_datagram_encoder_unit.
module urde_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input urde_pkg::rsp_type rsp
);

   logic [2:0] beats_ff, beats_in;
   logic       rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      beats_in = beats_ff;
      if (rsp_beat) begin
         beats_in = rsp.last ? 3'd0 : beats_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= 3'd0;
      end else begin
         beats_ff <= beats_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("Stalled rsp beat changed or dropped.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset.");

   a_sync_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && beats_ff == 3'd0 |-> rsp.tx_byte == urde_pkg::SYNC_BYTE)
      else $error("Datagram does not open with the sync byte.");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |-> beats_ff == 3'd3 || beats_ff == 3'd7)
      else $error("Datagram closed after a wrong number of beats.");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && beats_ff == 3'd7 |-> rsp.last)
      else $error("Datagram runs past eight beats.");

endmodule

bind uart_register_datagram_encoder_unit urde_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

### tb/uart_register_datagram_encoder_unit_test.sv
`timescale 1ns / 1ps
// Testbench for uart_register_datagram_encoder_unit: drives write and read requests and checks
// every rsp beat against datagrams predicted here with a bit-serial CRC-8.
// Depends on urde_pkg and the encoder RTL.
module uart_register_datagram_encoder_unit_test;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_REQUESTS = 500;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WRITE_BYTES     = 8;
   localparam int READ_BYTES      = 4;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   urde_pkg::req_type req       = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   urde_pkg::rsp_type rsp;

   urde_pkg::rsp_type expected_bytes[$];
   urde_pkg::rsp_type want_beat;
   int unsigned       failures         = 0;
   bit                no_idling        = 1'b0;
   int unsigned       hold_off_request = 0;
   int unsigned       hold_off_seen    = 0;
   int unsigned       stall_left       = 0;
   int unsigned       next_stall       = 0;
   int unsigned       cycle_count      = 0;

   uart_register_datagram_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idling) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic urde_pkg::req_type make_request(input logic mode,
                                                      input logic [7:0] node,
                                                      input logic [6:0] register_addr,
                                                      input logic [31:0] data);
      urde_pkg::req_type item;
      item.mode       = mode;
      item.node_addr  = node;
      item.reg_addr   = register_addr;
      item.write_data = data;
      return item;
   endfunction

   // The CRC runs over every byte before it, each byte least significant bit first.
   task automatic predict_datagram(input urde_pkg::req_type item);
      logic [7:0]        frame [WRITE_BYTES];
      logic [7:0]        crc;
      logic [7:0]        octet;
      int                len;
      urde_pkg::rsp_type beat;
      frame[0] = urde_pkg::SYNC_BYTE;
      frame[1] = item.node_addr;
      if (item.mode == urde_pkg::MODE_WRITE) begin
         frame[2] = urde_pkg::WRITE_FLAG | {1'b0, item.reg_addr};
         frame[3] = item.write_data[31:24];
         frame[4] = item.write_data[23:16];
         frame[5] = item.write_data[15:8];
         frame[6] = item.write_data[7:0];
         len = WRITE_BYTES;
      end else begin
         frame[2] = {1'b0, item.reg_addr};
         len = READ_BYTES;
      end
      crc = urde_pkg::CRC_INIT;
      for (int k = 0; k < len - 1; k++) begin
         octet = frame[k];
         for (int b = 0; b < 8; b++) begin
            crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ octet[0]) ? urde_pkg::CRC_POLY : 8'h00);
            octet = octet >> 1;
         end
      end
      frame[len - 1] = crc;
      for (int k = 0; k < len; k++) begin
         beat.tx_byte = frame[k];
         beat.last    = (k == len - 1);
         expected_bytes.push_back(beat);
      end
   endtask

   task automatic send_request(input urde_pkg::req_type item);
      int unsigned gap;
      req       <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_datagram(item);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_write_extremes();
      send_request(make_request(urde_pkg::MODE_WRITE, 8'h00, 7'h00, 32'h0000_0000));
      send_request(make_request(urde_pkg::MODE_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF));
      send_request(make_request(urde_pkg::MODE_WRITE, 8'h55, 7'h2A, 32'hA5A5_A5A5));
      send_request(make_request(urde_pkg::MODE_WRITE, 8'hAA, 7'h55, 32'h5A5A_5A5A));
      send_request(make_request(urde_pkg::MODE_WRITE, 8'h01, 7'h01, 32'h0000_0001));
      send_request(make_request(urde_pkg::MODE_WRITE, 8'h80, 7'h40, 32'h8000_0000));
   endtask

   // The data field of a read request must not reach the datagram.
   task automatic test_read_requests();
      send_request(make_request(urde_pkg::MODE_READ, 8'h00, 7'h00, 32'hFFFF_FFFF));
      send_request(make_request(urde_pkg::MODE_READ, 8'hFF, 7'h7F, 32'h0000_0000));
      send_request(make_request(urde_pkg::MODE_READ, 8'hA5, 7'h5A, 32'hDEAD_BEEF));
      send_request(make_request(urde_pkg::MODE_READ, 8'h5A, 7'h25, 32'h1234_5678));
   endtask

   task automatic test_back_to_back();
      no_idling = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_request(make_request((i % 2 == 0) ? urde_pkg::MODE_WRITE : urde_pkg::MODE_READ,
                                   8'($urandom), 7'($urandom), $urandom));
      end
      no_idling = 1'b0;
   endtask

   task automatic test_receiver_hold_off();
      no_idling = 1'b1;
      hold_off_request++;
      for (int i = 0; i < 8; i++) begin
         send_request(make_request(urde_pkg::MODE_WRITE, 8'($urandom), 7'($urandom),
                                   $urandom));
      end
      no_idling = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [31:0] data;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         case ($urandom_range(0, 9))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            default: data = $urandom;
         endcase
         no_idling = (i % 100) >= 80;
         send_request(make_request(1'($urandom_range(0, 1)), 8'($urandom), 7'($urandom),
                                   data));
      end
      no_idling = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_seen != hold_off_request) begin
         hold_off_seen <= hold_off_request;
         stall_left    <= HOLD_OFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1 || no_idling || $urandom_range(0, 99) >= 20) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else begin
         next_stall = pick_gap();
         stall_left <= next_stall;
         rsp_ready  <= (next_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            failures++;
            $display("%0t: unexpected beat, actual tx_byte %h last %b",
                     $time, rsp.tx_byte, rsp.last);
         end else begin
            want_beat = expected_bytes.pop_front();
            if (rsp.tx_byte !== want_beat.tx_byte) begin
               failures++;
               $display("%0t: tx_byte expected %h actual %h",
                        $time, want_beat.tx_byte, rsp.tx_byte);
            end
            if (rsp.last !== want_beat.last) begin
               failures++;
               $display("%0t: last expected %b actual %b", $time, want_beat.last, rsp.last);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("uart_register_datagram_encoder_unit_test failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_write_extremes();
      test_read_requests();
      test_back_to_back();
      test_receiver_hold_off();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("uart_register_datagram_encoder_unit_test passed");
      end else begin
         $display("uart_register_datagram_encoder_unit_test failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/urde_pkg.sv
sv/urde_front.sv
sv/urde_back.sv
sv/uart_register_datagram_encoder_unit.sv
sv/urde_checker.sv
tb/uart_register_datagram_encoder_unit_test.sv
